// ===== hdl/bct_pkg.sv =====
// Shared types and constants for the binned cross-tabulation block.
// No dependencies.
`default_nettype none
package bct_pkg;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] CSR_LOWEST_BOUND = 2'd0;
   localparam logic [1:0] CSR_CLASS_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_CLASS_COUNT  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIN,
      ST_SCAN,
      ST_APPLY,
      ST_OUT
   } state_type;

   // per-column cell control, row wide enough for the largest class count
   typedef struct packed {
      logic       clear;
      logic       shift;
      logic       load;
      logic       inc;
      logic [7:0] row;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== hdl/bct_binner.sv =====
// Iterative class finder: steps a fence up by one class width per cycle.
// Depends on bct_pkg.
`default_nettype none
module bct_binner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [32:0] offset,
   input  wire logic [30:0] width,
   input  wire logic [8:0]  classes,
   output logic             done,
   output logic [7:0]       cls
);
   import bct_pkg::*;

   logic        busy_ff, busy_in;
   logic [7:0]  cls_ff, cls_in;
   logic [36:0] fence_ff, fence_in;
   logic [36:0] step_ff, step_in;
   logic [32:0] offset_ff, offset_in;
   logic [7:0]  last_ff, last_in;
   logic        stop;

   always_comb begin
      stop = (cls_ff == last_ff) || ({4'b0, offset_ff} < fence_ff);
      busy_in   = busy_ff;
      cls_in    = cls_ff;
      fence_in  = fence_ff;
      step_in   = step_ff;
      offset_in = offset_ff;
      last_in   = last_ff;
      if (start) begin
         busy_in   = 1'b1;
         cls_in    = 8'd0;
         step_in   = (width == 31'd0) ? 37'd1 : {6'b0, width};
         fence_in  = (width == 31'd0) ? 37'd1 : {6'b0, width};
         offset_in = offset;
         last_in   = 8'(classes - 9'd1);
      end else if (busy_ff) begin
         if (stop) begin
            busy_in = 1'b0;
         end else begin
            cls_in   = cls_ff + 8'd1;
            fence_in = fence_ff + step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cls_ff    <= cls_in;
      fence_ff  <= fence_in;
      step_ff   <= step_in;
      offset_ff <= offset_in;
      last_ff   <= last_in;
   end

   assign done = busy_ff && stop;
   assign cls  = cls_ff;

endmodule
`default_nettype wire

// ===== hdl/bct_cell.sv =====
// One column of the table: label, column sum and per-class counts.
// Depends on bct_pkg; takes shifted contents from its left neighbour.
`default_nettype none
module bct_cell #(
   parameter int MAX_CLASSES = 16,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic                                    clock,
   input  wire bct_pkg::cell_ctl_type                   ctl,
   input  wire logic signed [31:0]                      new_value,
   input  wire logic signed [31:0]                      nb_value,
   input  wire logic [COUNT_BITS-1:0]                   nb_sum,
   input  wire logic [MAX_CLASSES-1:0][COUNT_BITS-1:0]  nb_counts,
   output logic signed [31:0]                           value,
   output logic [COUNT_BITS-1:0]                        sum,
   output logic [MAX_CLASSES-1:0][COUNT_BITS-1:0]       counts,
   output logic                                         lt,
   output logic                                         eq
);
   import bct_pkg::*;

   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   logic signed [31:0]                     label_ff, label_in;
   logic [COUNT_BITS-1:0]                  sum_ff, sum_in;
   logic [MAX_CLASSES-1:0][COUNT_BITS-1:0] counts_ff, counts_in;

   always_comb begin
      label_in  = label_ff;
      sum_in    = sum_ff;
      counts_in = counts_ff;
      if (ctl.clear) begin
         sum_in    = '0;
         counts_in = '0;
      end else if (ctl.shift) begin
         label_in  = nb_value;
         sum_in    = nb_sum;
         counts_in = nb_counts;
      end else if (ctl.load) begin
         label_in  = new_value;
         sum_in    = ctl.inc ? COUNT_BITS'(1) : '0;
         counts_in = '0;
         for (int r = 0; r < MAX_CLASSES; r++) begin
            if (ctl.inc && ctl.row == 8'(r)) begin
               counts_in[r] = COUNT_BITS'(1);
            end
         end
      end else if (ctl.inc) begin
         if (sum_ff != CMAX) begin
            sum_in = sum_ff + COUNT_BITS'(1);
         end
         for (int r = 0; r < MAX_CLASSES; r++) begin
            if (ctl.row == 8'(r) && counts_ff[r] != CMAX) begin
               counts_in[r] = counts_ff[r] + COUNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      label_ff  <= label_in;
      sum_ff    <= sum_in;
      counts_ff <= counts_in;
   end

   assign value  = label_ff;
   assign sum    = sum_ff;
   assign counts = counts_ff;
   assign lt     = label_ff < new_value;
   assign eq     = label_ff == new_value;

endmodule
`default_nettype wire

// ===== hdl/binned_cross_tabulation_top.sv =====
// Two-dimensional histogram over a sorted row of column cells. Words are
// taken one at a time: an add word in range first waits for the fence
// search in the binner, then the column search, the table update and the
// result register follow in order; read and clear do not wait for the
// search. The next word is taken only after the result leaves, so a result
// stall holds the block. Column insert shifts all used cells past the insert
// position together. Depends on bct_pkg, bct_binner and bct_cell.
`default_nettype none
module binned_cross_tabulation_top #(
   parameter int MAX_CLASSES = 16,
   parameter int MAX_COLUMNS = 16,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [31:0] req_x_value,
   input  wire logic signed [31:0] req_y_value,
   input  wire logic [3:0]         req_row_index,
   input  wire logic [3:0]         req_col_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_class_index,
   output logic                    rsp_counted,
   output logic [3:0]              rsp_col_position,
   output logic                    rsp_table_full,
   output logic [15:0]             rsp_cell_count,
   output logic signed [31:0]      rsp_col_label,
   output logic [15:0]             rsp_row_total,
   output logic [15:0]             rsp_col_total,
   output logic [15:0]             rsp_grand_total,
   output logic [4:0]              rsp_cols_used
);
   import bct_pkg::*;

   localparam int UW = $clog2(MAX_COLUMNS + 1);
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   state_type state_ff, state_in;

   logic signed [31:0] lb_ff;
   logic [30:0]        cw_ff;
   logic [4:0]         cc_ff;

   logic [1:0]         op_ff;
   logic signed [31:0] y_ff;
   logic [3:0]         row_ff, col_ff;
   logic               xok_ff;
   logic [7:0]         cls_ff, cls_in;
   logic [UW-1:0]      pos_ff, pos_in;
   logic               found_ff, found_in;
   logic [UW-1:0]      used_ff, used_in;
   logic [COUNT_BITS-1:0] rsum_ff [MAX_CLASSES];
   logic [COUNT_BITS-1:0] total_ff;

   logic [3:0]  o_cls_ff, o_pos_ff;
   logic        o_cnt_ff, o_full_ff;
   logic [15:0] o_cell_ff, o_rtot_ff, o_ctot_ff, o_gtot_ff;
   logic signed [31:0] o_label_ff;
   logic [4:0]  o_used_ff;

   logic        accept, bin_start, bin_done;
   logic [7:0]  bin_cls;
   logic [8:0]  classes;
   logic [32:0] offset;

   cell_ctl_type                           ctl   [MAX_COLUMNS];
   logic signed [31:0]                     val_w [MAX_COLUMNS];
   logic [COUNT_BITS-1:0]                  sum_w [MAX_COLUMNS];
   logic [MAX_CLASSES-1:0][COUNT_BITS-1:0] cnt_w [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0]                 lt_w, eq_w;

   logic full, ins, inc;
   logic [COUNT_BITS-1:0] sel_cell, sel_rtot, sel_ctot;
   logic signed [31:0]    sel_label;
   logic [31:0] w_cell, w_rtot, w_ctot, w_gtot, w_used, w_cls, w_pos;

   assign accept = req_valid && !req_stall;
   assign classes = (cc_ff == 5'd0) ? 9'd1 :
                    ({4'b0, cc_ff} > 9'(MAX_CLASSES)) ? 9'(MAX_CLASSES) : {4'b0, cc_ff};
   assign offset = {req_x_value[31], req_x_value} - {lb_ff[31], lb_ff};

   bct_binner u_binner (
      .clock   (clock),
      .reset   (reset),
      .start   (bin_start),
      .offset  (offset),
      .width   (cw_ff),
      .classes (classes),
      .done    (bin_done),
      .cls     (bin_cls)
   );

   for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
      if (i == 0) begin : g_first
         bct_cell #(.MAX_CLASSES(MAX_CLASSES), .COUNT_BITS(COUNT_BITS)) u_cell (
            .clock (clock), .ctl (ctl[i]), .new_value (y_ff),
            .nb_value ('0), .nb_sum ('0), .nb_counts ('0),
            .value (val_w[i]), .sum (sum_w[i]), .counts (cnt_w[i]),
            .lt (lt_w[i]), .eq (eq_w[i])
         );
      end else begin : g_rest
         bct_cell #(.MAX_CLASSES(MAX_CLASSES), .COUNT_BITS(COUNT_BITS)) u_cell (
            .clock (clock), .ctl (ctl[i]), .new_value (y_ff),
            .nb_value (val_w[i-1]), .nb_sum (sum_w[i-1]), .nb_counts (cnt_w[i-1]),
            .value (val_w[i]), .sum (sum_w[i]), .counts (cnt_w[i]),
            .lt (lt_w[i]), .eq (eq_w[i])
         );
      end
   end

   // column search: valid labels are sorted, so the lt flags form a thermometer
   always_comb begin
      pos_in   = '0;
      found_in = 1'b0;
      for (int i = 0; i < MAX_COLUMNS; i++) begin
         if (UW'(i) < used_ff) begin
            if (lt_w[i]) pos_in = UW'(i + 1);
            if (eq_w[i]) found_in = 1'b1;
         end
      end
   end

   assign full = !found_ff && (used_ff == UW'(MAX_COLUMNS));
   assign ins  = (state_ff == ST_APPLY) && (op_ff == OP_ADD) && !found_ff && !full;
   assign inc  = (state_ff == ST_APPLY) && (op_ff == OP_ADD) && xok_ff && !full;

   always_comb begin
      for (int i = 0; i < MAX_COLUMNS; i++) begin
         ctl[i].clear = (state_ff == ST_APPLY) && (op_ff == OP_CLEAR);
         ctl[i].shift = ins && (UW'(i) > pos_ff) && (UW'(i) <= used_ff);
         ctl[i].load  = ins && (UW'(i) == pos_ff);
         ctl[i].inc   = inc && (UW'(i) == pos_ff);
         ctl[i].row   = cls_ff;
      end
   end

   // read selection
   always_comb begin
      sel_cell  = '0;
      sel_rtot  = '0;
      sel_ctot  = '0;
      sel_label = '0;
      for (int i = 0; i < MAX_COLUMNS; i++) begin
         if ({28'b0, col_ff} == 32'(i) && UW'(i) < used_ff) begin
            sel_label = val_w[i];
            sel_ctot  = sum_w[i];
            for (int r = 0; r < MAX_CLASSES; r++) begin
               if ({28'b0, row_ff} == 32'(r)) sel_cell = cnt_w[i][r];
            end
         end
      end
      for (int r = 0; r < MAX_CLASSES; r++) begin
         if ({28'b0, row_ff} == 32'(r)) sel_rtot = rsum_ff[r];
      end
   end

   assign w_cell = 32'(sel_cell);
   assign w_rtot = 32'(sel_rtot);
   assign w_ctot = 32'(sel_ctot);
   assign w_gtot = 32'(total_ff);
   assign w_used = 32'(used_ff);
   assign w_cls  = 32'(cls_ff);
   assign w_pos  = 32'(pos_ff);

   assign cls_in = bin_done ? bin_cls : cls_ff;

   always_comb begin
      used_in = used_ff;
      if ((state_ff == ST_APPLY) && (op_ff == OP_CLEAR)) used_in = '0;
      else if (ins) used_in = used_ff + UW'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_BIN;
         ST_BIN:   if (op_ff != OP_ADD || !xok_ff || bin_done) state_in = ST_SCAN;
         ST_SCAN:  state_in = ST_APPLY;
         ST_APPLY: state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      bin_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            bin_start = req_valid && (req_opcode == OP_ADD) && (req_x_value >= lb_ff);
         end
         ST_OUT:  rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lb_ff    <= '0;
         cw_ff    <= 31'd1;
         cc_ff    <= 5'd16;
         used_ff  <= '0;
         total_ff <= '0;
         for (int r = 0; r < MAX_CLASSES; r++) rsum_ff[r] <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (csr_write) begin
            case (csr_index)
               CSR_LOWEST_BOUND: lb_ff <= csr_data;
               CSR_CLASS_WIDTH:  cw_ff <= csr_data[30:0];
               CSR_CLASS_COUNT:  cc_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         if ((state_ff == ST_APPLY) && (op_ff == OP_CLEAR)) begin
            total_ff <= '0;
            for (int r = 0; r < MAX_CLASSES; r++) rsum_ff[r] <= '0;
         end else if (inc) begin
            if (total_ff != CMAX) total_ff <= total_ff + COUNT_BITS'(1);
            for (int r = 0; r < MAX_CLASSES; r++) begin
               if (cls_ff == 8'(r) && rsum_ff[r] != CMAX) begin
                  rsum_ff[r] <= rsum_ff[r] + COUNT_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         y_ff   <= req_y_value;
         row_ff <= req_row_index;
         col_ff <= req_col_index;
         xok_ff <= req_x_value >= lb_ff;
         cls_ff <= '0;
      end else begin
         cls_ff <= cls_in;
      end
      if (state_ff == ST_SCAN) begin
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
      if (state_ff == ST_APPLY) begin
         o_cls_ff   <= '0;
         o_cnt_ff   <= 1'b0;
         o_pos_ff   <= '0;
         o_full_ff  <= 1'b0;
         o_cell_ff  <= '0;
         o_label_ff <= '0;
         o_rtot_ff  <= '0;
         o_ctot_ff  <= '0;
         o_gtot_ff  <= '0;
         o_used_ff  <= '0;
         case (op_ff)
            OP_ADD: begin
               o_cls_ff  <= xok_ff ? w_cls[3:0] : 4'd0;
               o_cnt_ff  <= xok_ff && !full;
               o_pos_ff  <= full ? 4'd0 : w_pos[3:0];
               o_full_ff <= full;
            end
            OP_READ: begin
               o_cell_ff  <= w_cell[15:0];
               o_label_ff <= sel_label;
               o_rtot_ff  <= w_rtot[15:0];
               o_ctot_ff  <= w_ctot[15:0];
               o_gtot_ff  <= w_gtot[15:0];
               o_used_ff  <= w_used[4:0];
            end
            default: ;
         endcase
      end
   end

   assign rsp_class_index  = o_cls_ff;
   assign rsp_counted      = o_cnt_ff;
   assign rsp_col_position = o_pos_ff;
   assign rsp_table_full   = o_full_ff;
   assign rsp_cell_count   = o_cell_ff;
   assign rsp_col_label    = o_label_ff;
   assign rsp_row_total    = o_rtot_ff;
   assign rsp_col_total    = o_ctot_ff;
   assign rsp_grand_total  = o_gtot_ff;
   assign rsp_cols_used    = o_used_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(MAX_COLUMNS))
      else $error("column count beyond store depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && op_ff == OP_CLEAR) |=> used_ff == '0 && total_ff == '0)
      else $error("clear left table contents");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid)
      else $error("result shown in cycle after accept");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      ins |-> used_ff < UW'(MAX_COLUMNS))
      else $error("insert into full column store");

endmodule
`default_nettype wire
